// File: design/tac_pkg.sv
// Shared types, constants and the log2 table for the thermistor temperature converter.
// No dependencies; every other design file uses this package.
`default_nettype none

package tac_pkg;

    // Sample and divider arithmetic.
    localparam int SAMPLE_W = 10;
    localparam logic [SAMPLE_W-1:0] ADC_MAX = 10'd1023;
    localparam int OHM_W = 20;
    localparam int T0_W = 15;
    localparam int BETA_W = 14;
    localparam int PROD_W = 30;
    localparam int LG_W = 21;

    // Result fields.
    localparam int RES_W = 32;
    localparam int TC_W = 17;
    localparam int TF_W = 18;
    localparam int TK_W = 17;
    localparam logic [TK_W-1:0] K_MAX = 17'd77315;
    localparam logic [TK_W-1:0] KELVIN_OFS = 17'd27315;
    localparam logic [TF_W-1:0] FAHRENHEIT_OFS = 18'd45967;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_R = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_R = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_T = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIRING = 3'd4;

    localparam int QUEUE_DEPTH = 4;

    // One classified sample on its way from the front end to the back end.
    typedef struct packed {
        logic                ok;
        logic [SAMPLE_W-1:0] num;
        logic [SAMPLE_W-1:0] den;
    } tac_item_t;

    // round(65536 * log2(1 + i/16)) for i = 0..16.
    function automatic logic [16:0] log2_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/tac_front.sv
// Front end: takes a sample, checks its range and picks the divider ratio terms.
// Depends on tac_pkg.
`default_nettype none

module tac_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tac_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          on_bottom,
    output logic                          item_valid,
    input  logic                          item_ready,
    output tac_pkg::tac_item_t            item
);

    logic                      valid_reg;
    tac_pkg::tac_item_t        item_reg;
    tac_pkg::tac_item_t        item_next;
    logic [tac_pkg::SAMPLE_W-1:0] diff;

    assign in_ready = !valid_reg || item_ready;

    always_comb
    begin
        diff = tac_pkg::ADC_MAX - sample;
        item_next.ok = (sample != '0) && (sample < tac_pkg::ADC_MAX);
        item_next.num = on_bottom ? diff : sample;
        item_next.den = on_bottom ? sample : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

// File: design/tac_queue.sv
// Small FIFO between the front end and the back end.
// Depends on tac_pkg for the item type.
`default_nettype none

module tac_queue #(
    parameter int DEPTH = tac_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tac_pkg::tac_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tac_pkg::tac_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tac_pkg::tac_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

// File: design/tac_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// The caller guarantees the quotient fits in Q_W bits. Depends on tac_pkg for defaults.
`default_nettype none

module tac_div #(
    parameter int NUM_W  = tac_pkg::PROD_W,
    parameter int DEN_W  = tac_pkg::SAMPLE_W,
    parameter int Q_W    = tac_pkg::PROD_W,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]     st_rem  [0:Q_W];
    logic [DEN_W-1:0]  st_den  [0:Q_W];
    logic [Q_W-1:0]    st_q    [0:Q_W];
    logic [SIDE_W-1:0] st_side [0:Q_W];
    logic              st_vld  [0:Q_W];

    assign st_rem[0] = CW'(num);
    assign st_den[0] = den;
    assign st_q[0] = '0;
    assign st_side[0] = side;
    assign st_vld[0] = in_valid;

    genvar s;
    generate
        for (s = 0; s < Q_W; s++)
        begin : g_stage
            localparam int K = Q_W - 1 - s;
            logic [CW-1:0]     den_sh;
            logic              take;
            logic [CW-1:0]     rem_reg;
            logic [DEN_W-1:0]  den_reg;
            logic [Q_W-1:0]    q_reg;
            logic [SIDE_W-1:0] side_reg;
            logic              vld_reg;

            assign den_sh = CW'(st_den[s]) << K;
            assign take = (st_rem[s] >= den_sh);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg <= 1'b0;
                else if (en)
                    vld_reg <= st_vld[s];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= take ? st_rem[s] - den_sh : st_rem[s];
                    den_reg <= st_den[s];
                    q_reg <= {st_q[s][Q_W-2:0], take};
                    side_reg <= st_side[s];
                end
            end

            assign st_rem[s+1] = rem_reg;
            assign st_den[s+1] = den_reg;
            assign st_q[s+1] = q_reg;
            assign st_side[s+1] = side_reg;
            assign st_vld[s+1] = vld_reg;
        end
    endgenerate

    assign out_valid = st_vld[Q_W];
    assign quot = st_q[Q_W];
    assign out_side = st_side[Q_W];

endmodule

`default_nettype wire

// File: design/tac_log2.sv
// Two-stage log2 unit in Q16: leading-one search and normalization, then table
// lookup with linear interpolation. Depends on tac_pkg.
`default_nettype none

module tac_log2 (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tac_pkg::PROD_W-1:0]  x,
    output logic [tac_pkg::LG_W-1:0]    lg
);

    logic [4:0]                  e;
    logic [tac_pkg::PROD_W-1:0]  g;
    logic [4:0]                  e_reg;
    logic [3:0]                  idx_reg;
    logic [27:0]                 rem_reg;
    logic [16:0]                 base;
    logic [12:0]                 step;
    logic [40:0]                 prod;
    logic [16:0]                 interp;
    logic [tac_pkg::LG_W-1:0]    lg_reg;

    // Position of the top set bit; zero input reads as one.
    always_comb
    begin
        e = '0;
        for (int i = 0; i < tac_pkg::PROD_W; i++)
        begin
            if (x[i])
                e = 5'(i);
        end
        g = x << (5'(tac_pkg::PROD_W - 1) - e);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e;
            idx_reg <= g[28:25];
            rem_reg <= {g[24:0], 3'b000};
        end
    end

    always_comb
    begin
        base = tac_pkg::log2_tab({1'b0, idx_reg});
        step = 13'(tac_pkg::log2_tab({1'b0, idx_reg} + 5'd1) - base);
        prod = 41'(step) * 41'(rem_reg);
        interp = base + 17'(prod[40:28]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lg_reg <= {e_reg, interp[15:0]};
    end

    assign lg = lg_reg;

endmodule

`default_nettype wire

// File: design/tac_back.sv
// Back end: resistance division, log ratio, beta equation, unit conversion and
// the output register. Depends on tac_pkg, tac_div and tac_log2.
`default_nettype none

module tac_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tac_pkg::tac_item_t            in_item,
    input  logic [tac_pkg::OHM_W-1:0]     rf,
    input  logic [tac_pkg::OHM_W-1:0]     r0,
    input  logic [tac_pkg::T0_W-1:0]      t0,
    input  logic [tac_pkg::BETA_W-1:0]    beta,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_ok,
    output logic [tac_pkg::RES_W-1:0]     out_res,
    output logic [tac_pkg::TC_W-1:0]      out_tc,
    output logic [tac_pkg::TF_W-1:0]      out_tf,
    output logic [tac_pkg::TK_W-1:0]      out_tk
);

    localparam int PW = tac_pkg::PROD_W;
    localparam int CH = 9;

    typedef struct packed {
        logic          ok;
        logic [PW-1:0] res;
    } tag_t;

    logic advance;

    // Multiplier stage ahead of the resistance divider.
    logic                         p1_vld_reg;
    logic                         p1_ok_reg;
    logic [PW-1:0]                p1_pa_reg;
    logic [PW-1:0]                p1_pb_reg;
    logic [tac_pkg::SAMPLE_W-1:0] p1_den_reg;

    logic                 dv_vld;
    logic [PW-1:0]        dv_q;
    logic [2*PW:0]        dv_side;
    logic [tac_pkg::LG_W-1:0] lga;
    logic [tac_pkg::LG_W-1:0] lgb;

    logic [CH-1:0] chain_vld_reg;
    tag_t          chain_tag_reg [CH];

    logic signed [16:0] k0;
    logic signed [21:0] s0_d_reg;
    logic               s1_neg_reg;
    logic [36:0]        s1_mp_reg;
    logic [29:0]        s1_kb_reg;
    logic [20:0]        mag;
    logic [36:0]        rnd;
    logic signed [21:0] s2_lnq_reg;
    logic [29:0]        s2_kb_reg;
    logic signed [38:0] s3_lk_reg;
    logic [36:0]        s3_nnb_reg;
    logic [20:0]        s3_b100_reg;
    logic signed [39:0] s4_dd_reg;
    logic [52:0]        s4_nn_reg;
    logic               s5_pos_reg;
    logic [38:0]        s5_ddu_reg;
    logic [53:0]        s5_n2_reg;
    logic               s6_sat_reg;
    logic [53:0]        s6_num_reg;
    logic [38:0]        s6_den_reg;

    logic                      tv_vld;
    logic [tac_pkg::TK_W-1:0]  tv_q;
    logic [PW+1:0]             tv_side;
    logic [tac_pkg::TK_W-1:0]  tk;

    logic                      f1_vld_reg;
    tag_t                      f1_tag_reg;
    logic [tac_pkg::TK_W-1:0]  f1_tk_reg;
    logic [19:0]               f1_x9_reg;
    logic                      f2_vld_reg;
    tag_t                      f2_tag_reg;
    logic [tac_pkg::TK_W-1:0]  f2_tk_reg;
    logic [39:0]               f2_prod_reg;

    logic                      out_valid_reg;
    logic                      out_ok_reg;
    logic [tac_pkg::RES_W-1:0] out_res_reg;
    logic [tac_pkg::TC_W-1:0]  out_tc_reg;
    logic [tac_pkg::TF_W-1:0]  out_tf_reg;
    logic [tac_pkg::TK_W-1:0]  out_tk_reg;

    // The whole pipeline moves when the output register is free.
    assign advance = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else if (advance)
            p1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_ok_reg <= in_item.ok;
            p1_pa_reg <= PW'(rf) * PW'(in_item.num);
            p1_pb_reg <= PW'(r0) * PW'(in_item.den);
            p1_den_reg <= in_item.den;
        end
    end

    tac_div #(
        .NUM_W  (PW),
        .DEN_W  (tac_pkg::SAMPLE_W),
        .Q_W    (PW),
        .SIDE_W (2 * PW + 1)
    ) u_res_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (p1_vld_reg),
        .num       (p1_pa_reg),
        .den       (p1_den_reg),
        .side      ({p1_ok_reg, p1_pa_reg, p1_pb_reg}),
        .out_valid (dv_vld),
        .quot      (dv_q),
        .out_side  (dv_side)
    );

    tac_log2 u_log_num (
        .clk (clk),
        .en  (advance),
        .x   (dv_side[2*PW-1:PW]),
        .lg  (lga)
    );

    tac_log2 u_log_den (
        .clk (clk),
        .en  (advance),
        .x   (dv_side[PW-1:0]),
        .lg  (lgb)
    );

    // Valid flag and sample tag ride alongside the temperature arithmetic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_vld_reg <= '0;
        else if (advance)
            chain_vld_reg <= {chain_vld_reg[CH-2:0], dv_vld};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            chain_tag_reg[0] <= '{ok: dv_side[2*PW], res: dv_q};
            for (int i = 1; i < CH; i++)
                chain_tag_reg[i] <= chain_tag_reg[i-1];
        end
    end

    assign k0 = 17'(signed'(t0)) + signed'(tac_pkg::KELVIN_OFS);

    always_comb
    begin
        mag = s0_d_reg[21] ? 21'(-s0_d_reg) : 21'(s0_d_reg);
        rnd = s1_mp_reg + 37'd32768;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_d_reg <= signed'({1'b0, lga}) - signed'({1'b0, lgb});

            s1_neg_reg <= s0_d_reg[21];
            s1_mp_reg <= 37'(mag) * 37'd45426;
            s1_kb_reg <= 30'(k0[15:0]) * 30'(beta);

            s2_lnq_reg <= s1_neg_reg ? -signed'({1'b0, rnd[36:16]})
                                     : signed'({1'b0, rnd[36:16]});
            s2_kb_reg <= s1_kb_reg;

            s3_lk_reg <= 39'(s2_lnq_reg) * 39'(k0);
            s3_nnb_reg <= 37'(s2_kb_reg) * 37'd100;
            s3_b100_reg <= 21'(beta) * 21'd100;

            s4_dd_reg <= signed'({3'b000, s3_b100_reg, 16'h0000})
                         + signed'({s3_lk_reg[38], s3_lk_reg});
            s4_nn_reg <= {s3_nnb_reg, 16'h0000};

            s5_pos_reg <= (s4_dd_reg > 40'sd0);
            s5_ddu_reg <= s4_dd_reg[38:0];
            s5_n2_reg <= {1'b0, s4_nn_reg} + {16'h0000, s4_dd_reg[38:1]};

            // A quotient past 17 bits, or a non-positive denominator, saturates hot.
            s6_sat_reg <= !s5_pos_reg || ({2'b00, s5_n2_reg} >= {s5_ddu_reg, 17'h00000});
            s6_num_reg <= s5_n2_reg;
            s6_den_reg <= s5_pos_reg ? s5_ddu_reg : 39'd1;
        end
    end

    tac_div #(
        .NUM_W  (54),
        .DEN_W  (39),
        .Q_W    (tac_pkg::TK_W),
        .SIDE_W (PW + 2)
    ) u_temp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (chain_vld_reg[CH-1]),
        .num       (s6_sat_reg ? 54'd0 : s6_num_reg),
        .den       (s6_den_reg),
        .side      ({chain_tag_reg[CH-1], s6_sat_reg}),
        .out_valid (tv_vld),
        .quot      (tv_q),
        .out_side  (tv_side)
    );

    assign tk = (tv_side[0] || (tv_q > tac_pkg::K_MAX)) ? tac_pkg::K_MAX : tv_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_vld_reg <= tv_vld;
            f2_vld_reg <= f1_vld_reg;
            out_valid_reg <= f2_vld_reg;
        end
    end

    // Fahrenheit: floor((9 * tk + 2) / 5) through a reciprocal of five in Q22.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_tag_reg <= tv_side[PW+1:1];
            f1_tk_reg <= tk;
            f1_x9_reg <= 20'(tk) * 20'd9 + 20'd2;

            f2_tag_reg <= f1_tag_reg;
            f2_tk_reg <= f1_tk_reg;
            f2_prod_reg <= 40'(f1_x9_reg) * 40'd838861;

            out_ok_reg <= f2_tag_reg.ok;
            if (f2_tag_reg.ok)
            begin
                out_res_reg <= tac_pkg::RES_W'(f2_tag_reg.res);
                out_tk_reg <= f2_tk_reg;
                out_tc_reg <= f2_tk_reg - tac_pkg::KELVIN_OFS;
                out_tf_reg <= f2_prod_reg[39:22] - tac_pkg::FAHRENHEIT_OFS;
            end
            else
            begin
                out_res_reg <= '0;
                out_tk_reg <= '0;
                out_tc_reg <= '0;
                out_tf_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok = out_ok_reg;
    assign out_res = out_res_reg;
    assign out_tc = out_tc_reg;
    assign out_tf = out_tf_reg;
    assign out_tk = out_tk_reg;

endmodule

`default_nettype wire

// File: design/thermistor_adc_to_temperature_top.sv
// NTC thermistor converter top level; depends on tac_pkg, tac_front, tac_queue, tac_back.
// Throughput is one sample per cycle when the output is not stalled. Most of the pipeline's
// length is the 30-stage resistance divider and the 17-stage temperature divider, one bit
// per stage.
// Reset (rst_n, asynchronous, active low) empties the pipeline and queue and loads the
// register defaults: 10000 ohm fixed resistor and R0, 25.00 C, beta 3950, bottom wiring.
`default_nettype none

module thermistor_adc_to_temperature_top #(
    parameter int QUEUE_DEPTH = tac_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Sample input. tdata: adc_sample[9:0], zero fill [15:10].
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,

    // Result output. tdata: resistance_ohms[31:0], temp_centi_c[48:32],
    // temp_centi_f[66:49], temp_centi_k[83:67], zero fill [87:84].
    // tuser: reading_valid.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [87:0]                       m_axis_tdata,
    output logic                              m_axis_tuser,

    // Register writes, index as listed: fixed resistor, nominal resistance,
    // nominal temperature, beta, wiring.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [tac_pkg::OHM_W-1:0]  fixed_r_reg;
    logic [tac_pkg::OHM_W-1:0]  nominal_r_reg;
    logic [tac_pkg::T0_W-1:0]   nominal_t_reg;
    logic [tac_pkg::BETA_W-1:0] beta_reg;
    logic                       on_bottom_reg;

    logic [tac_pkg::OHM_W-1:0]  rf_eff;
    logic [tac_pkg::OHM_W-1:0]  r0_eff;
    logic [tac_pkg::BETA_W-1:0] beta_eff;

    logic                 fq_valid;
    logic                 fq_ready;
    tac_pkg::tac_item_t   fq_item;
    logic                 qb_valid;
    logic                 qb_ready;
    tac_pkg::tac_item_t   qb_item;

    logic                         res_ok;
    logic [tac_pkg::RES_W-1:0]    res_ohms;
    logic [tac_pkg::TC_W-1:0]     res_tc;
    logic [tac_pkg::TF_W-1:0]     res_tf;
    logic [tac_pkg::TK_W-1:0]     res_tk;

    // Registers are always writable; writes to indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_r_reg <= 20'd10000;
            nominal_r_reg <= 20'd10000;
            nominal_t_reg <= 15'sd2500;
            beta_reg <= 14'd3950;
            on_bottom_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tac_pkg::REG_FIXED_R:   fixed_r_reg <= cfg_data;
                tac_pkg::REG_NOMINAL_R: nominal_r_reg <= cfg_data;
                tac_pkg::REG_NOMINAL_T: nominal_t_reg <= cfg_data[tac_pkg::T0_W-1:0];
                tac_pkg::REG_BETA:      beta_reg <= cfg_data[tac_pkg::BETA_W-1:0];
                tac_pkg::REG_WIRING:    on_bottom_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // A zero resistance or beta behaves as one.
    assign rf_eff = (fixed_r_reg == '0) ? 20'd1 : fixed_r_reg;
    assign r0_eff = (nominal_r_reg == '0) ? 20'd1 : nominal_r_reg;
    assign beta_eff = (beta_reg == '0) ? 14'd1 : beta_reg;

    // The front end registers each sample with its validity and ratio terms.
    tac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .sample     (s_axis_tdata[tac_pkg::SAMPLE_W-1:0]),
        .on_bottom  (on_bottom_reg),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    // The queue lets the front keep taking samples while the back end stalls.
    tac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // The back end is one pipeline that advances whenever its output register is free.
    tac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .rf        (rf_eff),
        .r0        (r0_eff),
        .t0        (nominal_t_reg),
        .beta      (beta_eff),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_ok    (res_ok),
        .out_res   (res_ohms),
        .out_tc    (res_tc),
        .out_tf    (res_tf),
        .out_tk    (res_tk)
    );

    assign m_axis_tdata = {4'h0, res_tk, res_tf, res_tc, res_ohms};
    assign m_axis_tuser = res_ok;

    // An out-of-range sample reports nothing but a cleared flag.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid reading carries nonzero data");

    // Kelvin result never leaves its saturation range.
    a_kelvin_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res_tk <= tac_pkg::K_MAX))
        else $error("kelvin result above saturation limit");

    // Celsius and kelvin views of one valid reading agree.
    a_celsius_kelvin: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (res_tc == res_tk - tac_pkg::KELVIN_OFS))
        else $error("celsius and kelvin results disagree");

endmodule

`default_nettype wire
